// File: rtl/vdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdm_pkg
// Shared widths, metric codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package vdm_pkg;

    localparam int ELEM_W = 16;
    localparam int DOT_W  = 42;
    localparam int NORM_W = 41;
    localparam int SQD_W  = 44;
    localparam int ABSD_W = 27;
    localparam int MAXD_W = 17;
    localparam int DIST_W = 48;
    localparam int PROD_W = 2 * NORM_W;
    localparam int ROOT_W = 43;
    localparam int ROOT_CNT_W = 6;
    localparam int NUM_W  = DOT_W + 17;
    localparam int QUO_W  = NUM_W;
    localparam int DIV_CNT_W = 6;
    localparam int MUL_CNT_W = 2;

    typedef enum logic [2:0] {
        MET_SQL2 = 3'd0,
        MET_L2   = 3'd1,
        MET_L1   = 3'd2,
        MET_COS  = 3'd3,
        MET_CHEB = 3'd4
    } metric_t;

    typedef struct packed {
        logic accumulate;
        logic snapshot;
        logic mul_step;
        logic root_load;
        logic root_step;
        logic div_load;
        logic div_step;
        logic emit;
    } vdm_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic root_done;
        logic div_done;
        logic root_zero;
    } vdm_sts_t;

endpackage

// File: rtl/vector_distance_metrics_unit.sv
`timescale 1ns / 1ps
// Result path: squared L2, L1, Chebyshev and unused codes go from the last pair
// to S_OUT; L2 adds the 41-step root; cosine adds the partial-product multiply,
// 41-step root and 59-step divide, and skips the divide on zero norm.
// Throughput: one pair per cycle while a vector streams; in_ready drops after a last
// pair until the result is registered, longer while a previous result waits.
// Reset: asynchronous active low clears accumulators, control and metric_select.
// ----------------------------------------------------------------------------
// vector_distance_metrics_unit
// Streaming squared L2/L2/L1/cosine/Chebyshev distance over element pairs.
// ----------------------------------------------------------------------------
module vector_distance_metrics_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [vdm_pkg::ELEM_W-1:0]   elem_first,
    input  logic signed [vdm_pkg::ELEM_W-1:0]   elem_second,
    input  logic                                last_pair,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [vdm_pkg::DIST_W-1:0]          distance,
    output logic                                zero_norm,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_wdata
);
    import vdm_pkg::*;

    vdm_cmd_t          cmd;
    vdm_sts_t          sts;
    logic [2:0]        metric_reg;
    logic [DIST_W-1:0] dv, dist_reg;
    logic              dz, zn_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            metric_reg <= '0;
        else if (cfg_we)
            metric_reg <= cfg_wdata;
    end

    vdm_controller u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .last_pair,
        .metric_select(metric_reg), .out_valid, .out_ready, .cmd, .sts
    );

    vdm_datapath u_dp (
        .clk, .rst_n, .cmd, .sts, .metric_select(metric_reg),
        .elem_first, .elem_second, .dist_value(dv), .dist_zero(dz)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            dist_reg <= dv;
            zn_reg   <= dz;
        end
    end

    assign distance  = dist_reg;
    assign zero_norm = zn_reg;
endmodule

// File: rtl/vdm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdm_datapath
// Accumulators, sequential multiplier, bit-serial root and divider.
// ----------------------------------------------------------------------------
module vdm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  vdm_pkg::vdm_cmd_t                   cmd,
    output vdm_pkg::vdm_sts_t                   sts,
    input  logic [2:0]                          metric_select,
    input  logic signed [vdm_pkg::ELEM_W-1:0]   elem_first,
    input  logic signed [vdm_pkg::ELEM_W-1:0]   elem_second,
    output logic [vdm_pkg::DIST_W-1:0]          dist_value,
    output logic                                dist_zero
);
    import vdm_pkg::*;

    logic signed [DOT_W-1:0]  dot_reg;
    logic [NORM_W-1:0]        nf_reg, ns_reg;
    logic [SQD_W-1:0]         sqd_reg;
    logic [ABSD_W-1:0]        absd_reg;
    logic [MAXD_W-1:0]        maxd_reg;

    logic signed [31:0]       pab, paa, pbb;
    logic signed [16:0]       diff;
    logic [16:0]              ad;
    logic [33:0]              adsq;
    logic signed [DOT_W:0]    dot_sum;
    logic [NORM_W:0]          nf_sum, ns_sum;
    logic [SQD_W:0]           sqd_sum;
    logic [ABSD_W:0]          absd_sum;

    always_comb
    begin
        pab  = elem_first * elem_second;
        paa  = elem_first * elem_first;
        pbb  = elem_second * elem_second;
        diff = 17'(elem_first) - 17'(elem_second);
        ad   = diff[16] ? 17'(-diff) : diff;
        adsq = ad * ad;
        dot_sum  = (DOT_W+1)'(dot_reg) + (DOT_W+1)'(pab);
        nf_sum   = (NORM_W+1)'(nf_reg) + (NORM_W+1)'($unsigned(paa));
        ns_sum   = (NORM_W+1)'(ns_reg) + (NORM_W+1)'($unsigned(pbb));
        sqd_sum  = (SQD_W+1)'(sqd_reg) + (SQD_W+1)'(adsq);
        absd_sum = (ABSD_W+1)'(absd_reg) + (ABSD_W+1)'(ad);
    end

    // snapshot registers for result calculation
    logic signed [DOT_W-1:0] sdot_reg;
    logic [NORM_W-1:0]       snf_reg, sns_reg;
    logic [SQD_W-1:0]        ssqd_reg;
    logic [ABSD_W-1:0]       sabsd_reg;
    logic [MAXD_W-1:0]       smaxd_reg;
    logic [2:0]              smet_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= '0;
            nf_reg   <= '0;
            ns_reg   <= '0;
            sqd_reg  <= '0;
            absd_reg <= '0;
            maxd_reg <= '0;
        end
        else if (cmd.accumulate)
        begin
            if (cmd.snapshot)
            begin
                dot_reg <= '0; nf_reg <= '0; ns_reg <= '0;
                sqd_reg <= '0; absd_reg <= '0; maxd_reg <= '0;
            end
            else
            begin
                if (dot_sum[DOT_W] != dot_sum[DOT_W-1])
                    dot_reg <= dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                              : {1'b0, {(DOT_W-1){1'b1}}};
                else
                    dot_reg <= dot_sum[DOT_W-1:0];
                nf_reg   <= nf_sum[NORM_W] ? '1 : nf_sum[NORM_W-1:0];
                ns_reg   <= ns_sum[NORM_W] ? '1 : ns_sum[NORM_W-1:0];
                sqd_reg  <= sqd_sum[SQD_W] ? '1 : sqd_sum[SQD_W-1:0];
                absd_reg <= absd_sum[ABSD_W] ? '1 : absd_sum[ABSD_W-1:0];
                if (ad > maxd_reg)
                    maxd_reg <= ad;
            end
        end
    end

    // final values including the last pair
    logic signed [DOT_W-1:0] fdot;
    logic [NORM_W-1:0]       fnf, fns;
    logic [SQD_W-1:0]        fsqd;
    logic [ABSD_W-1:0]       fabsd;
    logic [MAXD_W-1:0]       fmaxd;

    always_comb
    begin
        if (dot_sum[DOT_W] != dot_sum[DOT_W-1])
            fdot = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}}
                                  : {1'b0, {(DOT_W-1){1'b1}}};
        else
            fdot = dot_sum[DOT_W-1:0];
        fnf   = nf_sum[NORM_W] ? '1 : nf_sum[NORM_W-1:0];
        fns   = ns_sum[NORM_W] ? '1 : ns_sum[NORM_W-1:0];
        fsqd  = sqd_sum[SQD_W] ? '1 : sqd_sum[SQD_W-1:0];
        fabsd = absd_sum[ABSD_W] ? '1 : absd_sum[ABSD_W-1:0];
        fmaxd = (ad > maxd_reg) ? ad : maxd_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accumulate && cmd.snapshot)
        begin
            sdot_reg  <= fdot;
            snf_reg   <= fnf;
            sns_reg   <= fns;
            ssqd_reg  <= fsqd;
            sabsd_reg <= fabsd;
            smaxd_reg <= fmaxd;
            smet_reg  <= metric_select;
        end
    end

    // norm product: four 21x21 partial products, one per cycle
    logic [PROD_W-1:0]    prod_reg;
    logic [MUL_CNT_W-1:0] mcnt_reg;
    logic [20:0]          ma, mb;
    logic [41:0]          mpart;
    logic [PROD_W-1:0]    mterm;

    always_comb
    begin
        ma = mcnt_reg[0] ? 21'(snf_reg[NORM_W-1:21]) : snf_reg[20:0];
        mb = mcnt_reg[1] ? 21'(sns_reg[NORM_W-1:21]) : sns_reg[20:0];
        mpart = ma * mb;
        mterm = PROD_W'(mpart) << (21 * (32'(mcnt_reg[0]) + 32'(mcnt_reg[1])));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mcnt_reg <= '0;
        else if (cmd.snapshot && cmd.accumulate)
            mcnt_reg <= '0;
        else if (cmd.mul_step)
            mcnt_reg <= mcnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.snapshot && cmd.accumulate)
            prod_reg <= '0;
        else if (cmd.mul_step)
            prod_reg <= prod_reg + mterm;
    end

    assign sts.mul_done = (mcnt_reg == '1);

    // restoring square root, one result bit per cycle
    logic [PROD_W+1:0]     rrem_reg;
    logic [PROD_W-1:0]     rsrc_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [ROOT_CNT_W-1:0] rcnt_reg;
    logic [PROD_W+1:0]     rtrial, rshift;

    always_comb
    begin
        rshift = {rrem_reg[PROD_W-1:0], rsrc_reg[PROD_W-1 -: 2]};
        rtrial = (PROD_W+2)'({root_reg, 2'b01});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rcnt_reg <= '0;
        else if (cmd.root_load)
            rcnt_reg <= ROOT_CNT_W'(PROD_W / 2);
        else if (cmd.root_step && rcnt_reg != '0)
            rcnt_reg <= rcnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.root_load)
        begin
            rrem_reg <= '0;
            root_reg <= '0;
            rsrc_reg <= (smet_reg == MET_COS) ? prod_reg : PROD_W'(ssqd_reg);
        end
        else if (cmd.root_step && rcnt_reg != '0)
        begin
            rsrc_reg <= rsrc_reg << 2;
            if (rshift >= rtrial)
            begin
                rrem_reg <= rshift - rtrial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rrem_reg <= rshift;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign sts.root_done = (rcnt_reg == '0);
    assign sts.root_zero = (root_reg == '0);

    // signed floor division of dot*65536 by root, restoring
    logic [NUM_W-1:0]     dnum_reg;
    logic [ROOT_W:0]      drem_reg;
    logic [QUO_W-1:0]     quo_reg;
    logic                 dneg_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [NUM_W-1:0]     numabs;
    logic [ROOT_W:0]      dsh;

    always_comb
    begin
        numabs = sdot_reg[DOT_W-1] ? NUM_W'(-(NUM_W'(sdot_reg)) << 16)
                                   : NUM_W'(NUM_W'(sdot_reg) << 16);
        dsh = {drem_reg[ROOT_W-1:0], dnum_reg[NUM_W-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_load)
            dcnt_reg <= DIV_CNT_W'(NUM_W);
        else if (cmd.div_step && dcnt_reg != '0)
            dcnt_reg <= dcnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dnum_reg <= numabs;
            drem_reg <= '0;
            quo_reg  <= '0;
            dneg_reg <= sdot_reg[DOT_W-1];
        end
        else if (cmd.div_step && dcnt_reg != '0)
        begin
            dnum_reg <= dnum_reg << 1;
            if (dsh >= (ROOT_W+1)'(root_reg))
            begin
                drem_reg <= dsh - (ROOT_W+1)'(root_reg);
                quo_reg  <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dsh;
                quo_reg  <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
    end

    assign sts.div_done = (dcnt_reg == '0);

    // cosine: 65536 - floor(q), clamped to 0..131072
    logic signed [QUO_W+1:0] qs;
    logic signed [QUO_W+1:0] cr;
    logic [DIST_W-1:0]       cosv;

    always_comb
    begin
        if (dneg_reg)
            qs = -(QUO_W+2)'(quo_reg) - ((drem_reg != '0) ? 1 : 0);
        else
            qs = (QUO_W+2)'(quo_reg);
        cr = (QUO_W+2)'(65536) - qs;
        if (cr < 0)
            cosv = '0;
        else if (cr > (QUO_W+2)'(131072))
            cosv = DIST_W'(131072);
        else
            cosv = DIST_W'(cr);
    end

    always_comb
    begin
        dist_zero = 1'b0;
        case (smet_reg)
            MET_SQL2: dist_value = DIST_W'(ssqd_reg);
            MET_L2:   dist_value = DIST_W'(root_reg);
            MET_L1:   dist_value = DIST_W'(sabsd_reg);
            MET_CHEB: dist_value = DIST_W'(smaxd_reg);
            MET_COS:
            begin
                if (root_reg == '0)
                begin
                    dist_value = DIST_W'(65536);
                    dist_zero  = 1'b1;
                end
                else
                    dist_value = cosv;
            end
            default:  dist_value = '0;
        endcase
    end

endmodule

// File: rtl/vdm_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdm_controller
// Sequences accumulation, multiply, root, divide and result hand-off.
// ----------------------------------------------------------------------------
module vdm_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               last_pair,
    input  logic [2:0]         metric_select,
    output logic               out_valid,
    input  logic               out_ready,
    output vdm_pkg::vdm_cmd_t  cmd,
    input  vdm_pkg::vdm_sts_t  sts
);
    import vdm_pkg::*;

    typedef enum logic [6:0] {
        S_ACC  = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_RLD  = 7'b0000100,
        S_ROOT = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_DIVW = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] met_reg;
    logic       ov_reg, ov_next;
    logic       acc;

    assign in_ready  = (state_reg == S_ACC);
    assign acc       = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd = '0;
        cmd.accumulate = acc;
        cmd.snapshot   = acc && last_pair;
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        case (state_reg)
            S_ACC:
            begin
                if (acc && last_pair)
                begin
                    if (metric_select == MET_COS)
                        state_next = S_MUL;
                    else if (metric_select == MET_L2)
                        state_next = S_RLD;
                    else
                        state_next = S_OUT;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.mul_done)
                    state_next = S_RLD;
            end
            S_RLD:
            begin
                cmd.root_load = 1'b1;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (sts.root_done)
                    state_next = (met_reg == MET_COS && !sts.root_zero) ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                cmd.div_load = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_ACC;
                end
            end
            default: state_next = S_ACC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            ov_reg    <= 1'b0;
            met_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (acc && last_pair)
                met_reg <= metric_select;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_ACC)
        else $error("ready outside accumulate");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !ov_reg || out_ready)
        else $error("result overwritten");
    a_out_next: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("result not shown");
endmodule
